/* rtl/gcam_pkg.sv */
`default_nettype none
package gcam_pkg;

   // default sizes
   localparam int unsigned MAX_CHARS_DEF      = 8;
   localparam int unsigned WINDOW_DEPTH_DEF   = 64;
   localparam int unsigned GAP_BITS_DEF       = 4;
   localparam int unsigned MAX_TOTAL_DIST_DEF = 15;
   localparam int unsigned COUNT_BITS_DEF     = 32;

   // register field widths
   localparam int unsigned PATTERN_SYMBOLS_W = 64;
   localparam int unsigned PATTERN_LENGTH_W  = 4;
   localparam int unsigned GAP_FIELD_W       = 28;
   localparam int unsigned LENGTH_W          = 7;
   localparam int unsigned CHAR_LIMIT_W      = 8;
   localparam int unsigned TOTAL_LIMIT_W     = 4;
   localparam int unsigned SYMBOL_W          = 8;
   localparam int unsigned ENDING_W          = 32;
   localparam int unsigned TOTAL_W           = 48;
   localparam int unsigned CSR_INDEX_W       = 3;
   localparam int unsigned CSR_DATA_W        = 64;

   localparam logic [ENDING_W-1:0] OUT_CAP   = '1;
   localparam logic [TOTAL_W-1:0]  TOTAL_CAP = '1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_SYMBOLS = 3'd0,
      REG_PATTERN_LENGTH  = 3'd1,
      REG_GAP_MINS        = 3'd2,
      REG_GAP_MAXS        = 3'd3,
      REG_MIN_LENGTH      = 3'd4,
      REG_MAX_LENGTH      = 3'd5,
      REG_CHAR_LIMIT      = 3'd6,
      REG_TOTAL_LIMIT     = 3'd7
   } csr_index_type;

   // commands from controller to datapath
   typedef struct packed {
      logic start;
      logic sym_rd;
      logic dist_ld;
      logic row_rd;
      logic acc_add;
      logic row_wr;
      logic lvl_next;
      logic fin_rd;
      logic fin_add;
      logic lane_sum;
   } gcam_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic g_go;
      logic np_last;
      logic lvl_last;
      logic sum_last;
   } gcam_stat_type;

   // field idx of a packed register, zero when past 64 bits
   function automatic logic [63:0] get_field(logic [63:0] r, int unsigned idx,
                                             int unsigned bits);
      int unsigned sh;
      logic [63:0] mask;
      sh   = idx * bits;
      mask = (bits >= 64) ? '1 : ((64'(1) << bits) - 64'(1));
      if (sh >= 64) begin
         return '0;
      end
      return (r >> sh) & mask;
   endfunction

   function automatic logic [SYMBOL_W-1:0] abs_diff(logic [SYMBOL_W-1:0] a,
                                                    logic [SYMBOL_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage
`default_nettype wire

/* rtl/gcam_ctrl.sv */
`default_nettype none
module gcam_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   out_free,
   output logic                        load_out,
   input  wire gcam_pkg::gcam_stat_type stat,
   output gcam_pkg::gcam_cmd_type      cmd
);
   import gcam_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SYM, ST_DIST, ST_RD, ST_ACC, ST_WR, ST_LVL,
      ST_FRD, ST_FADD, ST_SUM, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // sequencing of one item
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SYM;
            end
         end
         ST_SYM: begin
            cmd.sym_rd = 1'b1;
            state_in   = ST_DIST;
         end
         ST_DIST: begin
            cmd.dist_ld = 1'b1;
            state_in    = ST_RD;
         end
         ST_RD: begin
            if (stat.g_go) begin
               cmd.row_rd = 1'b1;
               state_in   = ST_ACC;
            end else begin
               state_in = ST_WR;
            end
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_RD;
         end
         ST_WR: begin
            cmd.row_wr = 1'b1;
            state_in   = stat.np_last ? ST_LVL : ST_SYM;
         end
         ST_LVL: begin
            cmd.lvl_next = 1'b1;
            state_in     = stat.lvl_last ? ST_FRD : ST_SYM;
         end
         ST_FRD: begin
            cmd.fin_rd = 1'b1;
            state_in   = ST_FADD;
         end
         ST_FADD: begin
            cmd.fin_add = 1'b1;
            state_in    = stat.np_last ? ST_SUM : ST_FRD;
         end
         ST_SUM: begin
            cmd.lane_sum = 1'b1;
            if (stat.sum_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

/* rtl/gcam_dp.sv */
`default_nettype none
module gcam_dp #(
   parameter int unsigned MAX_CHARS      = gcam_pkg::MAX_CHARS_DEF,
   parameter int unsigned WINDOW_DEPTH   = gcam_pkg::WINDOW_DEPTH_DEF,
   parameter int unsigned GAP_BITS       = gcam_pkg::GAP_BITS_DEF,
   parameter int unsigned MAX_TOTAL_DIST = gcam_pkg::MAX_TOTAL_DIST_DEF,
   parameter int unsigned COUNT_BITS     = gcam_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire gcam_pkg::gcam_cmd_type                    cmd,
   output gcam_pkg::gcam_stat_type                        stat,
   input  wire logic [gcam_pkg::SYMBOL_W-1:0]             symbol,
   input  wire logic                                      start_of_sequence,
   input  wire logic [gcam_pkg::PATTERN_SYMBOLS_W-1:0]    pattern_symbols,
   input  wire logic [gcam_pkg::PATTERN_LENGTH_W-1:0]     pattern_length,
   input  wire logic [gcam_pkg::GAP_FIELD_W-1:0]          gap_mins,
   input  wire logic [gcam_pkg::GAP_FIELD_W-1:0]          gap_maxs,
   input  wire logic [gcam_pkg::LENGTH_W-1:0]             min_length,
   input  wire logic [gcam_pkg::LENGTH_W-1:0]             max_length,
   input  wire logic [gcam_pkg::CHAR_LIMIT_W-1:0]         char_limit,
   input  wire logic [gcam_pkg::TOTAL_LIMIT_W-1:0]        total_limit,
   output logic [COUNT_BITS-1:0]                          ending
);
   import gcam_pkg::*;

   localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
   localparam int unsigned SW   = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned BINS = MAX_TOTAL_DIST + 1;
   localparam int unsigned KW   = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int unsigned JW   = $clog2(MAX_CHARS);
   localparam int unsigned MW   = JW + 1;
   localparam int unsigned CW   = AW + GAP_BITS + 1;
   localparam int unsigned LW   = (SW + 1 > 8) ? SW + 1 : 8;
   localparam int unsigned RW   = BINS * COUNT_BITS;

   typedef logic [BINS-1:0][COUNT_BITS-1:0] row_type;

   function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
                                                     logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

   logic [AW-1:0]         wp_ff, wp_in;
   logic [SW-1:0]         seen_ff, seen_in;
   logic [JW-1:0]         j_ff, j_in;
   logic [AW-1:0]         np_ff, np_in;
   logic [GAP_BITS:0]     g_ff, g_in;
   logic [AW-1:0]         o_ff, o_in;
   logic [SYMBOL_W-1:0]   d_ff, d_in;
   logic                  ok_ff, ok_in;
   logic [SYMBOL_W-1:0]   d0_ff, d0_in;
   logic                  ok0_ff, ok0_in;
   logic                  first_ff, first_in;
   logic                  cur_ff, cur_in;
   logic [KW-1:0]         k_ff, k_in;
   row_type               acc_ff, acc_in;
   logic [COUNT_BITS-1:0] ending_ff, ending_in;

   logic [SYMBOL_W-1:0]   win_mem [WINDOW_DEPTH];
   logic [SYMBOL_W-1:0]   sym_q;
   logic [RW-1:0]         rows_mem [2**(AW+1)];
   logic [RW-1:0]         row_q;

   logic [MW-1:0]         m_eff;
   logic [SYMBOL_W-1:0]   tl_eff;
   logic [SYMBOL_W-1:0]   pc, plast;
   logic [GAP_BITS-1:0]   gmin, gmax;
   logic [AW-1:0]         sym_addr, o_now, wp_next;
   logic [SYMBOL_W-1:0]   d_now, d0_now;
   logic [AW:0]           row_addr;
   row_type               src_row, init_row, shifted, rd_row;
   logic [LW-1:0]         span;
   logic                  span_ok;

   // effective limits
   always_comb begin
      if (pattern_length < PATTERN_LENGTH_W'(2)) begin
         m_eff = MW'(2);
      end else if (32'(pattern_length) > MAX_CHARS) begin
         m_eff = MW'(MAX_CHARS);
      end else begin
         m_eff = MW'(pattern_length);
      end
      tl_eff = (32'(total_limit) > MAX_TOTAL_DIST) ? SYMBOL_W'(MAX_TOTAL_DIST)
                                                    : SYMBOL_W'(total_limit);
   end

   // per level fields
   assign pc    = SYMBOL_W'(get_field(pattern_symbols, 32'(j_ff), SYMBOL_W));
   assign plast = SYMBOL_W'(get_field(pattern_symbols, 32'(m_eff) - 1, SYMBOL_W));
   assign gmin  = GAP_BITS'(get_field(64'(gap_mins), 32'(j_ff), GAP_BITS));
   assign gmax  = GAP_BITS'(get_field(64'(gap_maxs), 32'(j_ff), GAP_BITS));

   // window addressing, newest symbol at wp
   assign wp_next  = (32'(wp_ff) == WINDOW_DEPTH - 1) ? '0 : wp_ff + AW'(1);
   assign sym_addr = (wp_ff >= np_ff) ? (wp_ff - np_ff)
                   : AW'((AW+1)'(wp_ff) + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(np_ff));
   assign o_now    = AW'(CW'(np_ff) - CW'(1) - CW'(g_ff));
   assign d_now    = abs_diff(sym_q, pc);
   assign d0_now   = abs_diff(symbol, plast);
   assign row_addr = cmd.row_rd ? {cur_ff, o_now} : {cur_ff, np_ff};

   // source row: the first level sees only the last character on offset zero
   always_comb begin
      for (int b = 0; b < BINS; b++) begin
         init_row[b] = (ok0_ff && 32'(d0_ff) == b) ? COUNT_BITS'(1) : '0;
      end
      rd_row  = row_type'(row_q);
      src_row = first_ff ? ((o_ff == '0) ? init_row : '0) : rd_row;
      shifted = row_type'(RW'(src_row) << (32'(d_ff) * COUNT_BITS));
   end

   assign span    = LW'(np_ff) + LW'(1);
   assign span_ok = (span >= LW'(min_length)) && (span <= LW'(max_length));

   // next state of the datapath registers
   always_comb begin
      wp_in     = wp_ff;
      seen_in   = seen_ff;
      j_in      = j_ff;
      np_in     = np_ff;
      g_in      = g_ff;
      o_in      = o_ff;
      d_in      = d_ff;
      ok_in     = ok_ff;
      d0_in     = d0_ff;
      ok0_in    = ok0_ff;
      first_in  = first_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      ending_in = ending_ff;
      if (cmd.start) begin
         wp_in     = wp_next;
         seen_in   = start_of_sequence ? SW'(1)
                   : ((32'(seen_ff) < WINDOW_DEPTH) ? seen_ff + SW'(1) : seen_ff);
         j_in      = JW'(m_eff - MW'(2));
         np_in     = '0;
         first_in  = 1'b1;
         cur_in    = 1'b0;
         d0_in     = d0_now;
         ok0_in    = (d0_now <= char_limit) && (d0_now <= tl_eff);
         k_in      = '0;
         ending_in = '0;
      end
      if (cmd.dist_ld) begin
         d_in   = d_now;
         ok_in  = (d_now <= char_limit) && (d_now <= tl_eff);
         g_in   = {1'b0, gmin};
         acc_in = '0;
      end
      if (cmd.row_rd) begin
         o_in = o_now;
      end
      if (cmd.acc_add) begin
         for (int b = 0; b < BINS; b++) begin
            if (b <= 32'(tl_eff)) begin
               acc_in[b] = sat_add(acc_ff[b], shifted[b]);
            end
         end
         g_in = g_ff + (GAP_BITS+1)'(1);
      end
      if (cmd.row_wr) begin
         np_in = np_ff + AW'(1);
      end
      if (cmd.lvl_next) begin
         cur_in   = ~cur_ff;
         first_in = 1'b0;
         j_in     = j_ff - JW'(1);
         np_in    = '0;
         acc_in   = '0;
      end
      if (cmd.fin_add) begin
         if (span_ok) begin
            for (int b = 0; b < BINS; b++) begin
               acc_in[b] = sat_add(acc_ff[b], rd_row[b]);
            end
         end
         np_in = np_ff + AW'(1);
      end
      if (cmd.lane_sum) begin
         ending_in = sat_add(ending_ff, acc_ff[k_ff]);
         k_in      = k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         seen_ff  <= '0;
         first_ff <= 1'b1;
         cur_ff   <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         seen_ff  <= seen_in;
         first_ff <= first_in;
         cur_ff   <= cur_in;
      end
      j_ff      <= j_in;
      np_ff     <= np_in;
      g_ff      <= g_in;
      o_ff      <= o_in;
      d_ff      <= d_in;
      ok_ff     <= ok_in;
      d0_ff     <= d0_in;
      ok0_ff    <= ok0_in;
      k_ff      <= k_in;
      acc_ff    <= acc_in;
      ending_ff <= ending_in;
   end

   // symbol window memory
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         win_mem[wp_next] <= symbol;
      end
      if (cmd.sym_rd) begin
         sym_q <= win_mem[sym_addr];
      end
   end

   // partial count rows, two banks of one row per offset
   always_ff @(posedge clock) begin
      if (cmd.row_wr) begin
         rows_mem[{~cur_ff, np_ff}] <= ok_ff ? RW'(acc_ff) : '0;
      end
      if (cmd.row_rd || cmd.fin_rd) begin
         row_q <= rows_mem[row_addr];
      end
   end

   // status
   assign stat.g_go     = (CW'(g_ff) <= CW'(gmax)) && (CW'(g_ff) < CW'(np_ff));
   assign stat.np_last  = ((SW'(np_ff) + SW'(1)) == seen_ff);
   assign stat.lvl_last = (j_ff == '0);
   assign stat.sum_last = (32'(k_ff) == BINS - 1);

   assign ending = ending_ff;

endmodule
`default_nettype wire

/* rtl/gap_constrained_approx_match_counter.sv */
// Gap-constrained approximate match counter.
// req_ channel: one sequence symbol per item, with start_of_sequence to open
// a new sequence. rsp_ channel: one result per item, the occurrences ending
// at that symbol (ending_here) and a running total since reset. Both saturate.
// csr_ channel: register writes by index (csr_ready is always high); write
// only while the block is idle.
// Sequencing: one item runs through the pattern levels one after another on a
// single row adder of MAX_TOTAL_DIST+1 saturating lanes. Each level visits
// every window offset n below the fill count A: it reads the symbol, loads the
// distance, reads and adds one row per admitted gap (up to 2^GAP_BITS), writes
// the row, and after the last offset it switches levels. The final sum reads
// the row of each offset, adds those whose span lies within the length limits,
// sums the MAX_TOTAL_DIST+1 lanes one by one, then hands off the result. The
// row adder and the single read port of the count memory set how long it takes.
// Throughput: one item at a time; req_ready is high only when idle. The
// result register lets a new item start while a finished result waits.
// Reset: registers return to reset values, window fill count and running
// total clear; rsp_valid drops. When rsp_ready is low the result holds and
// a second finished item waits in its last state until the register frees.
`default_nettype none
module gap_constrained_approx_match_counter #(
   parameter int unsigned MAX_CHARS      = gcam_pkg::MAX_CHARS_DEF,
   parameter int unsigned WINDOW_DEPTH   = gcam_pkg::WINDOW_DEPTH_DEF,
   parameter int unsigned GAP_BITS       = gcam_pkg::GAP_BITS_DEF,
   parameter int unsigned MAX_TOTAL_DIST = gcam_pkg::MAX_TOTAL_DIST_DEF,
   parameter int unsigned COUNT_BITS     = gcam_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [gcam_pkg::SYMBOL_W-1:0]      req_symbol,
   input  wire logic                               req_start_of_sequence,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [gcam_pkg::ENDING_W-1:0]           rsp_ending_here,
   output logic [gcam_pkg::TOTAL_W-1:0]            rsp_running_total,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [gcam_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gcam_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gcam_pkg::*;

   logic [PATTERN_SYMBOLS_W-1:0] pattern_symbols_ff, pattern_symbols_in;
   logic [PATTERN_LENGTH_W-1:0]  pattern_length_ff, pattern_length_in;
   logic [GAP_FIELD_W-1:0]       gap_mins_ff, gap_mins_in;
   logic [GAP_FIELD_W-1:0]       gap_maxs_ff, gap_maxs_in;
   logic [LENGTH_W-1:0]          min_length_ff, min_length_in;
   logic [LENGTH_W-1:0]          max_length_ff, max_length_in;
   logic [CHAR_LIMIT_W-1:0]      char_limit_ff, char_limit_in;
   logic [TOTAL_LIMIT_W-1:0]     total_limit_ff, total_limit_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ENDING_W-1:0]          ending_ff, ending_in;
   logic [TOTAL_W-1:0]           total_ff, total_in;

   gcam_cmd_type                 cmd;
   gcam_stat_type                stat;
   logic                         out_free;
   logic                         load_out;
   logic [COUNT_BITS-1:0]        ending_cnt;
   logic [63:0]                  ending64;
   logic [TOTAL_W:0]             total_sum;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      pattern_symbols_in = pattern_symbols_ff;
      pattern_length_in  = pattern_length_ff;
      gap_mins_in        = gap_mins_ff;
      gap_maxs_in        = gap_maxs_ff;
      min_length_in      = min_length_ff;
      max_length_in      = max_length_ff;
      char_limit_in      = char_limit_ff;
      total_limit_in     = total_limit_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_PATTERN_SYMBOLS: pattern_symbols_in = csr_data;
            REG_PATTERN_LENGTH:  pattern_length_in  = csr_data[PATTERN_LENGTH_W-1:0];
            REG_GAP_MINS:        gap_mins_in        = csr_data[GAP_FIELD_W-1:0];
            REG_GAP_MAXS:        gap_maxs_in        = csr_data[GAP_FIELD_W-1:0];
            REG_MIN_LENGTH:      min_length_in      = csr_data[LENGTH_W-1:0];
            REG_MAX_LENGTH:      max_length_in      = csr_data[LENGTH_W-1:0];
            REG_CHAR_LIMIT:      char_limit_in      = csr_data[CHAR_LIMIT_W-1:0];
            REG_TOTAL_LIMIT:     total_limit_in     = csr_data[TOTAL_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_symbols_ff <= '0;
         pattern_length_ff  <= PATTERN_LENGTH_W'(2);
         gap_mins_ff        <= '0;
         gap_maxs_ff        <= '0;
         min_length_ff      <= LENGTH_W'(1);
         max_length_ff      <= LENGTH_W'(64);
         char_limit_ff      <= '0;
         total_limit_ff     <= '0;
      end else begin
         pattern_symbols_ff <= pattern_symbols_in;
         pattern_length_ff  <= pattern_length_in;
         gap_mins_ff        <= gap_mins_in;
         gap_maxs_ff        <= gap_maxs_in;
         min_length_ff      <= min_length_in;
         max_length_ff      <= max_length_in;
         char_limit_ff      <= char_limit_in;
         total_limit_ff     <= total_limit_in;
      end
   end

   gcam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .load_out  (load_out),
      .stat      (stat),
      .cmd       (cmd)
   );

   gcam_dp #(
      .MAX_CHARS      (MAX_CHARS),
      .WINDOW_DEPTH   (WINDOW_DEPTH),
      .GAP_BITS       (GAP_BITS),
      .MAX_TOTAL_DIST (MAX_TOTAL_DIST),
      .COUNT_BITS     (COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .symbol            (req_symbol),
      .start_of_sequence (req_start_of_sequence),
      .pattern_symbols   (pattern_symbols_ff),
      .pattern_length    (pattern_length_ff),
      .gap_mins          (gap_mins_ff),
      .gap_maxs          (gap_maxs_ff),
      .min_length        (min_length_ff),
      .max_length        (max_length_ff),
      .char_limit        (char_limit_ff),
      .total_limit       (total_limit_ff),
      .ending            (ending_cnt)
   );

   // result register and saturating running total
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ending64  = 64'(ending_cnt);
   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(ending64);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ending_in    = ending_ff;
      total_in     = total_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         ending_in    = (ending64 > 64'(OUT_CAP)) ? OUT_CAP : ending64[ENDING_W-1:0];
         total_in     = (total_sum[TOTAL_W] || (ending64 > 64'(TOTAL_CAP)))
                        ? TOTAL_CAP : total_sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
      ending_ff <= ending_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ending_here   = ending_ff;
   assign rsp_running_total = total_ff;

endmodule
`default_nettype wire

/* rtl/gcam_checker.sv */
`default_nettype none
module gcam_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [gcam_pkg::ENDING_W-1:0]    rsp_ending_here,
   input wire logic [gcam_pkg::TOTAL_W-1:0]     rsp_running_total
);
   import gcam_pkg::*;

   // one item at a time: ready drops after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after an item was taken");

   // the running total includes the current count
   a_total_covers_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (64'(rsp_running_total) >= 64'(rsp_ending_here)))
      else $error("running total below the count of this item");

   // no result straight out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_total))
      else $error("stalled result changed");

endmodule

bind gap_constrained_approx_match_counter gcam_checker u_gcam_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_ending_here   (rsp_ending_here),
   .rsp_running_total (rsp_running_total)
);
`default_nettype wire
